// File: sv/hsi_pkg.sv
// Shared types, sizes and codes of the hash set insert/search block.
package hsi_pkg;

   localparam int unsigned BUCKETS  = 1024;
   localparam int unsigned WAYS     = 4;
   localparam int unsigned KEY_W    = 32;
   localparam int unsigned CNT_W    = 32;
   localparam int unsigned ROW_W    = WAYS * KEY_W;
   localparam int unsigned BUCKET_W = $clog2(BUCKETS);

   localparam bit BUCKETS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

   // floor(2^32 / BUCKETS): the estimate of |key| / BUCKETS is at most one short
   localparam logic [KEY_W-1:0] BUCKET_RECIP = KEY_W'((64'd1 << 32) / BUCKETS);

   localparam logic CMD_SEARCH = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   typedef struct packed {
      logic                    cmd;
      logic signed [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic             found;
      logic             stored;
      logic             bucket_full;
      logic [CNT_W-1:0] duplicate_total;
      logic [CNT_W-1:0] hit_total;
   } rsp_type;

   typedef struct packed {
      logic             found;
      logic             has_free;
      logic [WAYS-1:0]  valid_next;
      logic [ROW_W-1:0] row_next;
   } probe_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_REDUCE,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

endpackage

// File: sv/hsi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hsi_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/hsi_hash.sv
// Bucket index of a key: |key| reduced modulo the bucket count.
module hsi_hash import hsi_pkg::*; (
   input  logic                clock,
   input  logic [KEY_W-1:0]    key,
   output logic [BUCKET_W-1:0] bucket
);

   logic [KEY_W-1:0] mag;

   // the most negative key keeps its bit pattern, which is 2^31 unsigned
   assign mag = key[KEY_W-1] ? (KEY_W'(0) - key) : key;

   if (BUCKETS_POW2) begin : g_mask
      assign bucket = mag[BUCKET_W-1:0];
   end else begin : g_recip
      logic [2*KEY_W-1:0] prod_ff;
      logic [KEY_W-1:0]   quot;
      logic [KEY_W-1:0]   q_times_b;
      logic [KEY_W-1:0]   rem;
      logic [KEY_W-1:0]   rem_fix;

      // key is held steady by the caller while the reduction runs
      always_ff @(posedge clock) begin
         prod_ff <= (2*KEY_W)'(mag) * (2*KEY_W)'(BUCKET_RECIP);
      end

      assign quot      = prod_ff[2*KEY_W-1:KEY_W];
      assign q_times_b = KEY_W'(quot * KEY_W'(BUCKETS));
      assign rem       = mag - q_times_b;
      // quotient estimate may be one short: one correction step
      assign rem_fix   = (rem >= KEY_W'(BUCKETS)) ? (rem - KEY_W'(BUCKETS)) : rem;
      assign bucket    = rem_fix[BUCKET_W-1:0];
   end

endmodule

// File: sv/hsi_probe.sv
// Compare of a key against one bucket row and the row after an insert.
module hsi_probe import hsi_pkg::*; (
   input  logic [ROW_W-1:0] row,
   input  logic [WAYS-1:0]  valid,
   input  logic [KEY_W-1:0] key,
   output probe_type        probe
);

   logic [WAYS-1:0] hit;
   logic [WAYS-1:0] free;
   logic [WAYS-1:0] free_low;

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         hit[w] = valid[w] && (row[w*KEY_W +: KEY_W] == key);
      end
   end

   assign free     = ~valid;
   // isolate the lowest free way
   assign free_low = free & (WAYS'(0) - free);

   always_comb begin
      probe.found      = |hit;
      probe.has_free   = |free;
      probe.valid_next = valid | free_low;
      for (int w = 0; w < WAYS; w++) begin
         probe.row_next[w*KEY_W +: KEY_W] = free_low[w] ? key : row[w*KEY_W +: KEY_W];
      end
   end

endmodule

// File: sv/hash_set_insert_search.sv
// Top level of the hash set insert/search block.
//
// A set of signed 32-bit keys in BUCKETS buckets of WAYS ways each. Each request word
// searches for or inserts one key and gives one response word with the outcome and the
// saturating duplicate and hit totals. After reset the block clears the way-valid memory
// bucket by bucket and holds req_stall high meanwhile. One request is in work at a time:
// with a power-of-two bucket count a request reads the bucket row from the key and valid
// memories, then compares and writes back; with any other bucket count the hash, reduce
// and lookup states first compute the bucket index by a reciprocal multiply and read the
// row. A response that is not taken holds the next request in its compare step until the
// output register frees.
module hash_set_insert_search import hsi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   state_type           state_ff, state_in;
   logic [KEY_W-1:0]    key_ff;
   logic                cmd_ff;
   logic [BUCKET_W-1:0] bucket_ff, bucket_in;
   logic [BUCKET_W-1:0] clr_idx_ff, clr_idx_in;
   logic [CNT_W-1:0]    hit_ff, hit_in;
   logic [CNT_W-1:0]    dup_ff, dup_in;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff, rsp_next;

   logic                req_take;
   logic                rsp_free;
   logic                update_go;
   logic                clear_done;
   logic [KEY_W-1:0]    hash_key;
   logic [BUCKET_W-1:0] hash_bucket;
   logic [BUCKET_W-1:0] rd_addr;

   logic                valid_wr_en;
   logic [BUCKET_W-1:0] valid_wr_addr;
   logic [WAYS-1:0]     valid_wr_data;
   logic [WAYS-1:0]     valid_rd;
   logic                key_wr_en;
   logic [ROW_W-1:0]    key_rd;
   probe_type           probe;

   assign req_take   = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign update_go  = (state_ff == ST_UPDATE) && rsp_free;
   assign clear_done = (clr_idx_ff == BUCKET_W'(BUCKETS - 1));

   // while idle, hash the incoming key so the row read starts at the accept edge
   assign hash_key = (state_ff == ST_IDLE) ? req_data.key : key_ff;
   assign rd_addr  = (state_ff == ST_IDLE) ? hash_bucket : bucket_ff;

   hsi_hash u_hash (
      .clock  (clock),
      .key    (hash_key),
      .bucket (hash_bucket)
   );

   hsi_ram #(
      .WIDTH (WAYS),
      .DEPTH (BUCKETS)
   ) u_valid_ram (
      .clock   (clock),
      .wr_en   (valid_wr_en),
      .wr_addr (valid_wr_addr),
      .wr_data (valid_wr_data),
      .rd_addr (rd_addr),
      .rd_data (valid_rd)
   );

   hsi_ram #(
      .WIDTH (ROW_W),
      .DEPTH (BUCKETS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (bucket_ff),
      .wr_data (probe.row_next),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   hsi_probe u_probe (
      .row   (key_rd),
      .valid (valid_rd),
      .key   (key_ff),
      .probe (probe)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               state_in = BUCKETS_POW2 ? ST_UPDATE : ST_HASH;
            end
         end
         ST_HASH:   state_in = ST_REDUCE;
         ST_REDUCE: state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_CLEAR;
      endcase
   end

   // memory writes, counters and index registers
   always_comb begin
      valid_wr_en   = 1'b0;
      valid_wr_addr = bucket_ff;
      valid_wr_data = probe.valid_next;
      key_wr_en     = 1'b0;
      hit_in        = hit_ff;
      dup_in        = dup_ff;
      clr_idx_in    = clr_idx_ff;
      bucket_in     = bucket_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            valid_wr_en   = 1'b1;
            valid_wr_addr = clr_idx_ff;
            valid_wr_data = '0;
            clr_idx_in    = clr_idx_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_take && BUCKETS_POW2) begin
               bucket_in = hash_bucket;
            end
         end
         ST_REDUCE: begin
            bucket_in = hash_bucket;
         end
         ST_UPDATE: begin
            if (rsp_free) begin
               if (cmd_ff == CMD_INSERT) begin
                  if (probe.found) begin
                     dup_in = (&dup_ff) ? dup_ff : dup_ff + 1'b1;
                  end else if (probe.has_free) begin
                     valid_wr_en = 1'b1;
                     key_wr_en   = 1'b1;
                  end
               end else if (probe.found) begin
                  hit_in = (&hit_ff) ? hit_ff : hit_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_next.found           = probe.found;
      rsp_next.stored          = (cmd_ff == CMD_INSERT) && !probe.found && probe.has_free;
      rsp_next.bucket_full     = (cmd_ff == CMD_INSERT) && !probe.found && !probe.has_free;
      rsp_next.duplicate_total = dup_in;
      rsp_next.hit_total       = hit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         hit_ff       <= '0;
         dup_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_idx_ff <= clr_idx_in;
         hit_ff     <= hit_in;
         dup_ff     <= dup_in;
         if (update_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      bucket_ff <= bucket_in;
      if (req_take) begin
         key_ff <= req_data.key;
         cmd_ff <= req_data.cmd;
      end
      if (update_go) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: sv/hsi_checker.sv
// Port-level checks of the hash set insert/search block and their binding.
module hsi_checker import hsi_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic [CNT_W-1:0] last_hit_ff;
   logic [CNT_W-1:0] last_dup_ff;

   // hold the totals of the last word taken
   always_ff @(posedge clock) begin
      if (reset) begin
         last_hit_ff <= '0;
         last_dup_ff <= '0;
      end else if (rsp_valid && !rsp_stall) begin
         last_hit_ff <= rsp_data.hit_total;
         last_dup_ff <= rsp_data.duplicate_total;
      end
   end

   a_single_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($countones({rsp_data.found, rsp_data.stored, rsp_data.bucket_full}) <= 1))
      else $error("response word carries more than one outcome");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request word taken while one is in work");

   a_total_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (((rsp_data.hit_total == last_hit_ff)
                      || (rsp_data.hit_total == last_hit_ff + 1'b1))
                     && ((rsp_data.duplicate_total == last_dup_ff)
                      || (rsp_data.duplicate_total == last_dup_ff + 1'b1))))
      else $error("a total moved by more than one");

   a_one_counter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.hit_total == last_hit_ff)
                     || (rsp_data.duplicate_total == last_dup_ff)))
      else $error("both totals moved for one request");

   // a stalled request word must not change
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> $stable(req_data))
      else $error("request word changed while stalled");

endmodule

bind hash_set_insert_search hsi_checker u_checker (.*);

// File: tb/hsi_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the hash set block: predicts each response word and checks it on arrival.
package hsi_tb_pkg;
   import hsi_pkg::*;

   class set_scoreboard;
      logic [KEY_W-1:0] key_mem [BUCKETS*WAYS];
      logic [WAYS-1:0]  way_used [BUCKETS];
      logic [CNT_W-1:0] dup_count;
      logic [CNT_W-1:0] hit_count;
      rsp_type          pending_outcomes [$];
      int               mismatches;

      function new();
         foreach (way_used[i]) way_used[i] = '0;
         dup_count  = '0;
         hit_count  = '0;
         mismatches = 0;
      endfunction

      // |key| mod BUCKETS; the most negative key keeps its magnitude 2^31 as unsigned
      function logic [BUCKET_W-1:0] bucket_index(logic [KEY_W-1:0] k);
         logic [KEY_W-1:0] mag;
         mag = k[KEY_W-1] ? -k : k;
         return BUCKET_W'(mag % BUCKETS);
      endfunction

      function int outstanding();
         return pending_outcomes.size();
      endfunction

      function void note_request(req_type w);
         logic [BUCKET_W-1:0] b;
         logic [WAYS-1:0]     used;
         rsp_type             o;
         int                  free_way;
         b        = bucket_index(w.key);
         used     = way_used[b];
         o        = '0;
         free_way = -1;
         for (int i = 0; i < WAYS; i++) begin
            if (used[i]) begin
               if (key_mem[b*WAYS + i] == w.key) o.found = 1'b1;
            end else if (free_way < 0) begin
               free_way = i;
            end
         end
         if (w.cmd == CMD_SEARCH) begin
            if (o.found && hit_count != '1) hit_count++;
         end else if (o.found) begin
            if (dup_count != '1) dup_count++;
         end else if (free_way >= 0) begin
            key_mem[b*WAYS + free_way] = w.key;
            way_used[b][free_way]      = 1'b1;
            o.stored                   = 1'b1;
         end else begin
            o.bucket_full = 1'b1;
         end
         o.duplicate_total = dup_count;
         o.hit_total       = hit_count;
         pending_outcomes.push_back(o);
      endfunction

      function void flag_field(string field, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_outcomes.size() == 0) begin
            $display("%0t: response expected none, got %0h", $time, got);
            mismatches++;
            return;
         end
         want = pending_outcomes.pop_front();
         flag_field("found", want.found, got.found);
         flag_field("stored", want.stored, got.stored);
         flag_field("bucket_full", want.bucket_full, got.bucket_full);
         flag_field("duplicate_total", want.duplicate_total, got.duplicate_total);
         flag_field("hit_total", want.hit_total, got.hit_total);
      endfunction
   endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench top: drives search and insert words into the hash set and checks every response.
module tb_top;
   import hsi_pkg::*;
   import hsi_tb_pkg::*;

   localparam int RANDOM_WORDS = 1150;
   localparam int HOT_COUNT    = 24;
   localparam int CYCLE_LIMIT  = 500000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   set_scoreboard             words;
   logic [BUCKET_W-1:0]       hot_bucket [HOT_COUNT];
   logic signed [KEY_W-1:0]   recent_keys [$];
   bit                        steady;
   int                        rx_hold  = 0;
   int                        rx_quiet = 0;
   int unsigned               cycles   = 0;

   hash_set_insert_search dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("hash_set_insert_search verification failed");
         $finish;
      end
   end

   function automatic int idle_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
   endfunction

   // Receiver: check accepted words, stall in short and long bursts with quiet stretches
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) words.check_response(rsp_data);
      if (rx_hold == 0 && rx_quiet == 0) begin
         if ($urandom_range(0, 99) < 3) rx_quiet = $urandom_range(40, 200);
         else if ($urandom_range(0, 99) < 30) rx_hold = idle_len();
      end
      if (rx_hold > 0) begin
         rx_hold--;
         rsp_stall <= 1'b1;
      end else begin
         if (rx_quiet > 0) rx_quiet--;
         rsp_stall <= 1'b0;
      end
   end

   function automatic req_type word_of(logic cmd, logic [KEY_W-1:0] key);
      req_type w;
      w.cmd = cmd;
      w.key = key;
      return w;
   endfunction

   // Mostly keys that collide in a few hot buckets, some replays, some fully random
   function automatic req_type random_word();
      req_type     w;
      int unsigned r;
      int unsigned mag;
      r     = $urandom_range(0, 99);
      w.cmd = 1'($urandom_range(0, 1));
      if (r < 20 && recent_keys.size() > 0) begin
         w.key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      end else if (r < 35) begin
         w.key = $urandom();
      end else begin
         mag = hot_bucket[$urandom_range(0, HOT_COUNT - 1)] + BUCKETS *
               (($urandom_range(0, 7) == 0) ? $urandom_range(0, 2097150) : $urandom_range(0, 5));
         w.key = $urandom_range(0, 1) ? -mag : mag;
      end
      recent_keys.push_back(w.key);
      if (recent_keys.size() > 48) void'(recent_keys.pop_front());
      return w;
   endfunction

   task automatic send_word(input req_type w, input bit drain);
      int gap;
      gap = (drain || steady || $urandom_range(0, 99) < 55) ? 0 : idle_len();
      if (drain || gap > 0) begin
         req_valid <= 1'b0;
         @(posedge clock);
         // hold off until the block has answered everything
         while (drain && words.outstanding() != 0) @(posedge clock);
         repeat (gap > 1 ? gap - 1 : 0) @(posedge clock);
      end
      req_data  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      words.note_request(w);
   endtask

   task automatic run_directed();
      send_word(word_of(CMD_SEARCH, 32'h0000_0000), 1'b0);
      send_word(word_of(CMD_INSERT, 32'h0000_0000), 1'b0);
      send_word(word_of(CMD_SEARCH, 32'h0000_0000), 1'b0);
      send_word(word_of(CMD_INSERT, 32'h0000_0000), 1'b0);
      // most negative key lands in bucket zero
      send_word(word_of(CMD_INSERT, 32'h8000_0000), 1'b0);
      send_word(word_of(CMD_SEARCH, 32'h8000_0000), 1'b0);
      send_word(word_of(CMD_INSERT, 32'h0000_0400), 1'b0);
      send_word(word_of(CMD_INSERT, 32'hFFFF_FC00), 1'b0);
      // bucket zero now full: drop a new key, still find a present one
      send_word(word_of(CMD_INSERT, 32'h0000_0800), 1'b0);
      send_word(word_of(CMD_SEARCH, 32'h0000_0800), 1'b0);
      send_word(word_of(CMD_INSERT, 32'hFFFF_FC00), 1'b0);
      send_word(word_of(CMD_SEARCH, 32'hFFFF_FC00), 1'b0);
      send_word(word_of(CMD_INSERT, 32'h7FFF_FFFF), 1'b0);
      send_word(word_of(CMD_INSERT, 32'h8000_0001), 1'b0);
      send_word(word_of(CMD_SEARCH, 32'h7FFF_FFFF), 1'b0);
      send_word(word_of(CMD_SEARCH, 32'h8000_0001), 1'b0);
      send_word(word_of(CMD_INSERT, 32'hFFFF_FFFF), 1'b0);
      send_word(word_of(CMD_SEARCH, 32'h0000_0001), 1'b0);
      send_word(word_of(CMD_INSERT, 32'h0000_0001), 1'b0);
      send_word(word_of(CMD_SEARCH, 32'hFFFF_FFFF), 1'b0);
      send_word(word_of(CMD_INSERT, 32'h0000_0001), 1'b0);
   endtask

   task automatic run_random();
      hot_bucket[0] = '0;
      hot_bucket[1] = BUCKET_W'(BUCKETS - 1);
      for (int i = 2; i < HOT_COUNT; i++) hot_bucket[i] = BUCKET_W'($urandom_range(0, BUCKETS - 1));
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 64 == 0) steady = ($urandom_range(0, 3) == 0);
         send_word(random_word(), i == RANDOM_WORDS / 2);
      end
   endtask

   initial begin
      words  = new();
      steady = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      req_valid <= 1'b0;
      while (words.outstanding() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (words.mismatches == 0)
         $display("hash_set_insert_search verification clean");
      else
         $display("hash_set_insert_search verification failed");
      $finish;
   end

endmodule

// File: filelist.f
sv/hsi_pkg.sv
sv/hsi_ram.sv
sv/hsi_hash.sv
sv/hsi_probe.sv
sv/hash_set_insert_search.sv
sv/hsi_checker.sv
tb/hsi_tb_pkg.sv
tb/tb_top.sv
